// ----- hw/rtl/mep_pkg.sv -----
package mep_pkg;

  // Fixed-point format: signed Q6.26
  localparam int FIX_W      = 32;
  localparam int STEP_W     = 27;
  localparam int FRAC_BITS  = 26;
  localparam int SAT_W      = 48;

  // Defaults for the top-level parameters
  localparam int MAX_ITER_DEF   = 64;
  localparam int COORD_BITS_DEF = 12;

  // Result field widths
  localparam int RED_W     = 8;
  localparam int CNT_OUT_W = 7;

  // Red level: min(255, 6400 / count); counts up to this value saturate
  localparam int             RED_NUM_W    = 13;
  localparam logic [12:0]    RED_NUM      = 13'd6400;
  localparam int             RED_FULL_CNT = 25;
  localparam logic [RED_W-1:0] RED_MAX    = 8'hFF;
  localparam int             QUO_BITS     = 8;

  // Escape bound: 16.0 in Q12.52
  localparam logic [64:0] ESC_LIMIT = 65'h0_0100_0000_0000_0000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_X_STEP   = 2'd0,
    CFG_Y_STEP   = 2'd1,
    CFG_X_OFFSET = 2'd2,
    CFG_Y_OFFSET = 2'd3
  } cfg_idx_e;

  localparam logic [STEP_W-1:0]       X_STEP_RST   = 27'd655;
  localparam logic [STEP_W-1:0]       Y_STEP_RST   = 27'd655;
  localparam logic signed [FIX_W-1:0] X_OFFSET_RST = 32'sd26843546;
  localparam logic signed [FIX_W-1:0] Y_OFFSET_RST = 32'sd13421773;

  typedef struct packed {
    logic [STEP_W-1:0]       x_step;
    logic [STEP_W-1:0]       y_step;
    logic signed [FIX_W-1:0] x_offset;
    logic signed [FIX_W-1:0] y_offset;
  } cfg_t;

  // Point c handed from the front end to the iteration engine
  typedef struct packed {
    logic signed [FIX_W-1:0] re;
    logic signed [FIX_W-1:0] im;
  } cpt_t;

  typedef struct packed {
    logic [RED_W-1:0]     red_level;
    logic [CNT_OUT_W-1:0] iteration_count;
    logic                 inside_set;
  } res_t;

  // Saturate a wide signed value to Q6.26
  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [SAT_W-1:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return FIX_W'(v);
  endfunction

endpackage

// ----- hw/rtl/mep_ifs.sv -----
// Pixel coordinate channel
interface mep_pix_if #(
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// Color result channel
interface mep_res_if;
  logic                           valid;
  logic                           ready;
  logic [mep_pkg::RED_W-1:0]      red_level;
  logic [mep_pkg::CNT_OUT_W-1:0]  iteration_count;
  logic                           inside_set;

  modport source (output valid, output red_level, output iteration_count,
                  output inside_set, input ready);
  modport sink   (input valid, input red_level, input iteration_count,
                  input inside_set, output ready);
endinterface

// ----- hw/rtl/mep_front.sv -----
// Front end: takes a pixel item and maps it to the point c
module mep_front #(
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mep_pix_if.sink         pix_i,
  input  mep_pkg::cfg_t   cfg_i,
  input  logic            full_i,
  output logic            push_o,
  output mep_pkg::cpt_t   push_data_o
);

  localparam int PROD_W = COORD_BITS + mep_pkg::STEP_W;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_e;

  fstate_e                 state_q;
  logic [COORD_BITS-1:0]   px_q, py_q;
  logic [PROD_W-1:0]       prod_x_q, prod_y_q;
  logic signed [mep_pkg::SAT_W-1:0] sum_x, sum_y;

  // Product plus offset, saturated to Q6.26
  always_comb begin
    sum_x = mep_pkg::SAT_W'(signed'({1'b0, prod_x_q})) + mep_pkg::SAT_W'(cfg_i.x_offset);
    sum_y = mep_pkg::SAT_W'(signed'({1'b0, prod_y_q})) + mep_pkg::SAT_W'(cfg_i.y_offset);
    push_data_o.re = mep_pkg::sat_fix(sum_x);
    push_data_o.im = mep_pkg::sat_fix(sum_y);
  end

  assign pix_i.ready = (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      px_q     <= '0;
      py_q     <= '0;
      prod_x_q <= '0;
      prod_y_q <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (pix_i.valid) begin
            px_q    <= pix_i.pixel_x;
            py_q    <= pix_i.pixel_y;
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          prod_x_q <= PROD_W'(px_q) * PROD_W'(cfg_i.x_step);
          prod_y_q <= PROD_W'(py_q) * PROD_W'(cfg_i.y_step);
          state_q  <= F_PUSH;
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/mep_cq.sv -----
// Two-entry queue of points between front end and iteration engine
module mep_cq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mep_pkg::cpt_t  push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mep_pkg::cpt_t  pop_data_o
);

  mep_pkg::cpt_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/mep_back.sv -----
// Iteration engine: z = z*z + c, escape test, red level by shift-subtract
module mep_back #(
  parameter int MAX_ITER = mep_pkg::MAX_ITER_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  mep_pkg::cpt_t  pop_data_i,
  output logic           pop_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output mep_pkg::res_t  res_o
);

  localparam int CNT_W = $clog2(MAX_ITER + 2);
  localparam int CMP_W = (CNT_W + mep_pkg::QUO_BITS > mep_pkg::RED_NUM_W) ?
                         CNT_W + mep_pkg::QUO_BITS : mep_pkg::RED_NUM_W;
  localparam int EXT_W = CNT_W + mep_pkg::CNT_OUT_W;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_STEP, B_DIV, B_FIN} bstate_e;

  bstate_e                          state_q;
  mep_pkg::cpt_t                    c_q;
  logic signed [mep_pkg::FIX_W-1:0] re_q, im_q;
  logic signed [63:0]               rr_q, ii_q, ri_q;
  logic [CNT_W-1:0]                 cnt_q;
  logic [mep_pkg::RED_NUM_W-1:0]    rem_q;
  logic [2:0]                       k_q;
  logic [mep_pkg::RED_W-1:0]        red_q;
  logic                             inside_q;
  logic                             res_vld_q;
  mep_pkg::res_t                    res_q;

  logic [64:0]                      mag;
  logic signed [64:0]               diff;
  logic                             cont;
  logic signed [mep_pkg::FIX_W-1:0] nre, nim;
  logic [CMP_W-1:0]                 remx, dvs;
  logic                             ge;
  logic [EXT_W-1:0]                 cnt_ext;
  logic                             res_load;

  // Escape test and next z from the registered products
  always_comb begin
    mag  = {1'b0, rr_q} + {1'b0, ii_q};
    cont = (mag <= mep_pkg::ESC_LIMIT) && (int'(cnt_q) <= MAX_ITER);
    diff = 65'(rr_q) - 65'(ii_q);
    nre  = mep_pkg::sat_fix(mep_pkg::SAT_W'(diff >>> mep_pkg::FRAC_BITS) +
                            mep_pkg::SAT_W'(c_q.re));
    nim  = mep_pkg::sat_fix(mep_pkg::SAT_W'(ri_q >>> (mep_pkg::FRAC_BITS - 1)) +
                            mep_pkg::SAT_W'(c_q.im));
  end

  // One quotient bit per cycle
  always_comb begin
    remx = CMP_W'(rem_q);
    dvs  = CMP_W'(cnt_q) << k_q;
    ge   = (remx >= dvs);
  end

  assign cnt_ext     = {{mep_pkg::CNT_OUT_W{1'b0}}, cnt_q};
  assign res_load    = (state_q == B_FIN) && (!res_vld_q || res_ready_i);
  assign pop_o       = (state_q == B_IDLE) && pop_valid_i;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      c_q       <= '0;
      re_q      <= '0;
      im_q      <= '0;
      rr_q      <= '0;
      ii_q      <= '0;
      ri_q      <= '0;
      cnt_q     <= '0;
      rem_q     <= '0;
      k_q       <= '0;
      red_q     <= '0;
      inside_q  <= 1'b0;
      res_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      // Output register: loads from the engine, drains on ready
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end

      unique case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            c_q     <= pop_data_i;
            re_q    <= '0;
            im_q    <= '0;
            cnt_q   <= '0;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          rr_q    <= re_q * re_q;
          ii_q    <= im_q * im_q;
          ri_q    <= re_q * im_q;
          state_q <= B_STEP;
        end
        B_STEP: begin
          if (cont) begin
            re_q    <= nre;
            im_q    <= nim;
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= B_MUL;
          end else if (int'(cnt_q) > MAX_ITER) begin
            inside_q <= 1'b1;
            red_q    <= '0;
            state_q  <= B_FIN;
          end else if (int'(cnt_q) <= mep_pkg::RED_FULL_CNT) begin
            inside_q <= 1'b0;
            red_q    <= mep_pkg::RED_MAX;
            state_q  <= B_FIN;
          end else begin
            inside_q <= 1'b0;
            red_q    <= '0;
            rem_q    <= mep_pkg::RED_NUM;
            k_q      <= 3'(mep_pkg::QUO_BITS - 1);
            state_q  <= B_DIV;
          end
        end
        B_DIV: begin
          if (ge) begin
            rem_q      <= mep_pkg::RED_NUM_W'(remx - dvs);
            red_q[k_q] <= 1'b1;
          end
          if (k_q == 3'd0) begin
            state_q <= B_FIN;
          end else begin
            k_q <= k_q - 3'd1;
          end
        end
        B_FIN: begin
          if (res_load) begin
            res_q.red_level       <= red_q;
            res_q.iteration_count <= cnt_ext[mep_pkg::CNT_OUT_W-1:0];
            res_q.inside_set      <= inside_q;
            state_q               <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/mandelbrot_escape_pixel.sv -----
// Mandelbrot escape-time pixel engine. Each pixel item (pixel_x, pixel_y) is mapped to
// c = (pixel_x*x_step + x_offset, pixel_y*y_step + y_offset) in signed Q6.26, saturated;
// z = z*z + c is iterated from z = 0 while |z|^2 <= 16 and the count is at most MAX_ITER.
// The result carries the iteration count (1 to MAX_ITER+1, low 7 bits), inside_set when
// the limit was passed (red 0), else red = min(255, 6400/count). A front end forms c and
// hands it through a two-entry queue, so the next pixel is taken while the engine still
// iterates. Each escape test runs three 32x32 multipliers, then the registered test and
// update; the engine runs count+1 tests, then an 8-bit shift-subtract division when count
// is above 25, and then loads the output register.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must write them only while idle, as the block itself does not enforce this.
module mandelbrot_escape_pixel #(
  parameter int MAX_ITER   = mep_pkg::MAX_ITER_DEF,
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [mep_pkg::FIX_W-1:0]  cfg_wdata_i,
  mep_pix_if.sink                    pix_i,
  mep_res_if.source                  res_o
);

  mep_pkg::cfg_t cfg_q;
  logic          push, full, pop, q_valid;
  mep_pkg::cpt_t push_data, pop_data;
  mep_pkg::res_t res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_step   <= mep_pkg::X_STEP_RST;
      cfg_q.y_step   <= mep_pkg::Y_STEP_RST;
      cfg_q.x_offset <= mep_pkg::X_OFFSET_RST;
      cfg_q.y_offset <= mep_pkg::Y_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (mep_pkg::cfg_idx_e'(cfg_idx_i))
        mep_pkg::CFG_X_STEP:   cfg_q.x_step   <= cfg_wdata_i[mep_pkg::STEP_W-1:0];
        mep_pkg::CFG_Y_STEP:   cfg_q.y_step   <= cfg_wdata_i[mep_pkg::STEP_W-1:0];
        mep_pkg::CFG_X_OFFSET: cfg_q.x_offset <= signed'(cfg_wdata_i);
        mep_pkg::CFG_Y_OFFSET: cfg_q.y_offset <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  mep_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .cfg_i       (cfg_q),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mep_cq u_cq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  mep_back #(
    .MAX_ITER (MAX_ITER)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.red_level       = res.red_level;
  assign res_o.iteration_count = res.iteration_count;
  assign res_o.inside_set      = res.inside_set;

endmodule
